@@ rtl/bsrw_pkg.sv @@
// Shared types and constants for the bus stall reset watchdog.
package bsrw_pkg;

    localparam int CNT_W     = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] SDA_HIGH_LIMIT_RST = 16'd640;
    localparam logic [CNT_W-1:0] SDA_LOW_LIMIT_RST  = 16'd80;
    localparam logic [CNT_W-1:0] REQUEST_LIMIT_RST  = 16'h0008;
    localparam logic [CNT_W-1:0] PULSE_LENGTH_RST   = 16'h000F;

    localparam logic [CFG_IDX_W-1:0] REG_SDA_HIGH_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SDA_LOW_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REQUEST_LIMIT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_LENGTH   = 2'd3;

    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_HIGH    = 2'd1;
    localparam logic [1:0] CAUSE_LOW     = 2'd2;
    localparam logic [1:0] CAUSE_REQUEST = 2'd3;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_EDGE = 1'b1;

    typedef struct packed {
        logic operation;
        logic sda_level;
        logic request_level;
    } item_t;

    typedef struct packed {
        logic       relay_on;
        logic       report_n;
        logic       blocked;
        logic [1:0] cause;
    } result_t;

    typedef struct packed {
        logic [CNT_W-1:0] sda_high_limit;
        logic [CNT_W-1:0] sda_low_limit;
        logic [CNT_W-1:0] request_limit;
        logic [CNT_W-1:0] pulse_length;
    } limits_t;

endpackage

@@ rtl/bsrw_if.sv @@
// Valid/ready channel interfaces for input words and result words.
interface bsrw_item_if
    import bsrw_pkg::*;
;
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface bsrw_result_if
    import bsrw_pkg::*;
;
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/bsrw_cfg.sv @@
// Configuration register file holding the four watchdog limits.
module bsrw_cfg
    import bsrw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data,
    output limits_t              limits
);

    limits_t limits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.sda_high_limit <= SDA_HIGH_LIMIT_RST;
            limits_reg.sda_low_limit  <= SDA_LOW_LIMIT_RST;
            limits_reg.request_limit  <= REQUEST_LIMIT_RST;
            limits_reg.pulse_length   <= PULSE_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SDA_HIGH_LIMIT: limits_reg.sda_high_limit <= cfg_data;
                REG_SDA_LOW_LIMIT:  limits_reg.sda_low_limit  <= cfg_data;
                REG_REQUEST_LIMIT:  limits_reg.request_limit  <= cfg_data;
                REG_PULSE_LENGTH:   limits_reg.pulse_length   <= cfg_data;
                default:            limits_reg                <= limits_reg;
            endcase
        end
    end

    assign limits = limits_reg;

endmodule

@@ rtl/bsrw_core.sv @@
// Watchdog state registers and the single-pass update for one word.
module bsrw_core
    import bsrw_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  limits_t limits,
    output result_t status_next
);

    logic [CNT_W-1:0] high_count_reg, high_count_next;
    logic [CNT_W-1:0] low_count_reg, low_count_next;
    logic [CNT_W-1:0] request_count_reg, request_count_next;
    logic [CNT_W-1:0] pulse_count_reg, pulse_count_next;
    logic             block_reg, block_next;
    logic [1:0]       cause_reg, cause_next;
    logic             relay_reg, relay_next;
    logic             report_reg, report_next;

    always_comb
    begin
        high_count_next    = high_count_reg;
        low_count_next     = low_count_reg;
        request_count_next = request_count_reg;
        pulse_count_next   = pulse_count_reg;
        block_next         = block_reg;
        cause_next         = cause_reg;
        relay_next         = relay_reg;
        report_next        = report_reg;

        if (step)
        begin
            if (item.operation == OP_EDGE)
            begin
                if (!block_reg)
                begin
                    high_count_next    = '0;
                    low_count_next     = '0;
                    request_count_next = '0;
                end
            end
            else
            begin
                // The request check runs first and can block the data-line check.
                if (!item.request_level && !block_next)
                begin
                    if (request_count_reg < limits.request_limit)
                    begin
                        request_count_next = request_count_reg + 16'd1;
                    end
                    else
                    begin
                        cause_next         = CAUSE_REQUEST;
                        block_next         = 1'b1;
                        pulse_count_next   = '0;
                        request_count_next = '0;
                    end
                end

                if (item.sda_level && !block_next)
                begin
                    if (high_count_reg < limits.sda_high_limit)
                    begin
                        high_count_next = high_count_reg + 16'd1;
                    end
                    else
                    begin
                        cause_next       = CAUSE_HIGH;
                        block_next       = 1'b1;
                        pulse_count_next = '0;
                        high_count_next  = '0;
                    end
                end
                else if (!item.sda_level && !block_next)
                begin
                    if (low_count_reg < limits.sda_low_limit)
                    begin
                        low_count_next = low_count_reg + 16'd1;
                    end
                    else
                    begin
                        cause_next       = CAUSE_LOW;
                        block_next       = 1'b1;
                        pulse_count_next = '0;
                        low_count_next   = '0;
                    end
                end

                if (cause_next != CAUSE_NONE)
                begin
                    if (relay_reg)
                    begin
                        pulse_count_next = pulse_count_next + 16'd1;
                        if (pulse_count_next > limits.pulse_length)
                        begin
                            relay_next  = 1'b0;
                            cause_next  = CAUSE_NONE;
                            block_next  = 1'b0;
                            report_next = 1'b1;
                        end
                    end
                    else
                    begin
                        relay_next       = 1'b1;
                        pulse_count_next = '0;
                        report_next      = 1'b0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_count_reg    <= '0;
            low_count_reg     <= '0;
            request_count_reg <= '0;
            pulse_count_reg   <= '0;
            block_reg         <= 1'b0;
            cause_reg         <= CAUSE_NONE;
            relay_reg         <= 1'b0;
            report_reg        <= 1'b1;
        end
        else
        begin
            high_count_reg    <= high_count_next;
            low_count_reg     <= low_count_next;
            request_count_reg <= request_count_next;
            pulse_count_reg   <= pulse_count_next;
            block_reg         <= block_next;
            cause_reg         <= cause_next;
            relay_reg         <= relay_next;
            report_reg        <= report_next;
        end
    end

    assign status_next.relay_on = relay_next;
    assign status_next.report_n = report_next;
    assign status_next.blocked  = block_next;
    assign status_next.cause    = cause_next;

endmodule

@@ rtl/bus_stall_reset_watchdog.sv @@
// Top level of the bus stall reset watchdog with input and result registers.
// An accepted word waits in the input register, then its result is registered.
// Throughput: one word per cycle while the result side keeps taking words.
// The result register frees a slot in the same cycle its word is taken.
// Reset: rst_n clears all counters, the cause, the block and the relay.
// After reset the report is inactive and the limits take their default values.
module bus_stall_reset_watchdog
    import bsrw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    bsrw_item_if.sink            item,
    bsrw_result_if.source        result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CNT_W-1:0]     cfg_data
);

    item_t   item_reg;
    logic    item_valid_reg;
    result_t result_reg;
    logic    result_valid_reg;
    logic    advance;
    limits_t limits;
    result_t status_next;

    assign advance    = item_valid_reg && (!result_valid_reg || result.ready);
    assign item.ready = !item_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
            begin
                item_valid_reg <= item.valid;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            item_reg <= item.data;
        end
        if (advance)
        begin
            result_reg <= status_next;
        end
    end

    bsrw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .limits    (limits)
    );

    bsrw_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (item_reg),
        .limits      (limits),
        .status_next (status_next)
    );

    assign result.valid = result_valid_reg;
    assign result.data  = result_reg;

endmodule

@@ rtl/bsrw_checker.sv @@
// Port-level assertions for the watchdog and the bind that attaches them.
module bsrw_checker
    import bsrw_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result_data
);

    // The report is always the inverse of the relay drive.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.report_n == !result_data.relay_on))
        else $error("report_n does not mirror relay_on");

    // A latched cause and the block are set and cleared together.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result_data.blocked == (result_data.cause != CAUSE_NONE)))
        else $error("blocked and cause disagree");

    // The relay is only on while a reset episode is in progress.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_data.relay_on) |-> result_data.blocked)
        else $error("relay on without block");

    // A stalled result word holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result_data)))
        else $error("stalled result word changed");

endmodule

bind bus_stall_reset_watchdog bsrw_checker u_bsrw_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);

@@ sim/bus_stall_reset_watchdog_tb.sv @@
// Self-checking testbench for the bus stall reset watchdog: directed table, then random phases.
module bus_stall_reset_watchdog_tb
    import bsrw_pkg::*;
;

    localparam int PROBE_ROWS         = 22;
    localparam int PROBE_DEFAULT_ROWS = 2;
    localparam int PHASES             = 8;
    localparam int PHASE_WORDS        = 172;
    localparam int QUIET_LIMIT        = 3000;
    localparam int LONG_HOLD          = 300;
    localparam int LONG_HOLD_AFTER    = 500;
    localparam int SETTLE_CYCLES      = 8;
    localparam int MAX_REPORTS        = 10;

    localparam result_t STATUS_IDLE =
        '{relay_on: 1'b0, report_n: 1'b1, blocked: 1'b0, cause: CAUSE_NONE};
    localparam result_t STATUS_HIGH =
        '{relay_on: 1'b1, report_n: 1'b0, blocked: 1'b1, cause: CAUSE_HIGH};
    localparam result_t STATUS_LOW =
        '{relay_on: 1'b1, report_n: 1'b0, blocked: 1'b1, cause: CAUSE_LOW};
    localparam result_t STATUS_REQUEST =
        '{relay_on: 1'b1, report_n: 1'b0, blocked: 1'b1, cause: CAUSE_REQUEST};

    typedef struct {
        item_t   word;
        bit      typed;
        result_t want;
    } probe_row_t;

    typedef struct {
        bit      typed;
        result_t want;
    } typed_status_t;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CNT_W-1:0] cfg_data;

    bsrw_item_if   item_bus ();
    bsrw_result_if status_bus ();

    bus_stall_reset_watchdog dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_bus),
        .result    (status_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    logic [CNT_W-1:0] lim_high;
    logic [CNT_W-1:0] lim_low;
    logic [CNT_W-1:0] lim_request;
    logic [CNT_W-1:0] lim_pulse;
    logic [CNT_W-1:0] wd_high;
    logic [CNT_W-1:0] wd_low;
    logic [CNT_W-1:0] wd_request;
    logic [CNT_W-1:0] wd_pulse;
    logic             wd_blocked;
    logic [1:0]       wd_cause;
    logic             wd_relay;
    logic             wd_report_n;

    result_t       status_expected [$];
    typed_status_t typed_notes [$];
    int unsigned   mismatches;
    int unsigned   words_in;
    int unsigned   quiet_cycles;
    bit            steady;

    probe_row_t probe_rows [PROBE_ROWS] = '{
        '{'{OP_EDGE, 1'b1, 1'b0}, 1'b1, STATUS_IDLE},
        '{'{OP_TICK, 1'b1, 1'b1}, 1'b1, STATUS_IDLE},
        '{'{OP_EDGE, 1'b1, 1'b0}, 1'b1, STATUS_IDLE},
        '{'{OP_TICK, 1'b0, 1'b1}, 1'b1, STATUS_LOW},
        '{'{OP_EDGE, 1'b0, 1'b1}, 1'b1, STATUS_LOW},
        '{'{OP_TICK, 1'b1, 1'b0}, 1'b0, STATUS_IDLE},
        '{'{OP_TICK, 1'b1, 1'b1}, 1'b0, STATUS_IDLE},
        '{'{OP_TICK, 1'b1, 1'b1}, 1'b0, STATUS_IDLE},
        '{'{OP_TICK, 1'b1, 1'b1}, 1'b0, STATUS_IDLE},
        '{'{OP_EDGE, 1'b0, 1'b0}, 1'b0, STATUS_IDLE},
        '{'{OP_TICK, 1'b1, 1'b1}, 1'b0, STATUS_IDLE},
        '{'{OP_TICK, 1'b1, 1'b1}, 1'b0, STATUS_IDLE},
        '{'{OP_TICK, 1'b1, 1'b1}, 1'b1, STATUS_HIGH},
        '{'{OP_TICK, 1'b0, 1'b1}, 1'b0, STATUS_IDLE},
        '{'{OP_TICK, 1'b0, 1'b1}, 1'b0, STATUS_IDLE},
        '{'{OP_TICK, 1'b1, 1'b0}, 1'b0, STATUS_IDLE},
        '{'{OP_TICK, 1'b1, 1'b0}, 1'b1, STATUS_REQUEST},
        '{'{OP_TICK, 1'b1, 1'b1}, 1'b0, STATUS_IDLE},
        '{'{OP_TICK, 1'b1, 1'b1}, 1'b0, STATUS_IDLE},
        '{'{OP_TICK, 1'b0, 1'b0}, 1'b1, STATUS_LOW},
        '{'{OP_TICK, 1'b0, 1'b0}, 1'b0, STATUS_IDLE},
        '{'{OP_TICK, 1'b0, 1'b0}, 1'b0, STATUS_IDLE}
    };

    function automatic void latch_cause(input logic [1:0] why);
        wd_cause   = why;
        wd_blocked = 1'b1;
        wd_pulse   = '0;
    endfunction

    function automatic result_t next_status(input item_t w);
        result_t s;
        if (w.operation == OP_EDGE)
        begin
            if (!wd_blocked)
            begin
                wd_high    = '0;
                wd_low     = '0;
                wd_request = '0;
            end
        end
        else
        begin
            if (w.request_level == 1'b0 && !wd_blocked)
            begin
                if (wd_request < lim_request)
                    wd_request = wd_request + 1'b1;
                else
                begin
                    latch_cause(CAUSE_REQUEST);
                    wd_request = '0;
                end
            end
            if (!wd_blocked)
            begin
                if (w.sda_level)
                begin
                    if (wd_high < lim_high)
                        wd_high = wd_high + 1'b1;
                    else
                    begin
                        latch_cause(CAUSE_HIGH);
                        wd_high = '0;
                    end
                end
                else
                begin
                    if (wd_low < lim_low)
                        wd_low = wd_low + 1'b1;
                    else
                    begin
                        latch_cause(CAUSE_LOW);
                        wd_low = '0;
                    end
                end
            end
            if (wd_cause != CAUSE_NONE)
            begin
                if (wd_relay)
                begin
                    wd_pulse = wd_pulse + 1'b1;
                    if (wd_pulse > lim_pulse)
                    begin
                        wd_relay    = 1'b0;
                        wd_cause    = CAUSE_NONE;
                        wd_blocked  = 1'b0;
                        wd_report_n = 1'b1;
                    end
                end
                else
                begin
                    wd_relay    = 1'b1;
                    wd_pulse    = '0;
                    wd_report_n = 1'b0;
                end
            end
        end
        s.relay_on = wd_relay;
        s.report_n = wd_report_n;
        s.blocked  = wd_blocked;
        s.cause    = wd_cause;
        return s;
    endfunction

    function automatic int idle_cycles();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic send_word(input item_t w, input bit typed, input result_t want);
        int gap;
        typed_status_t note;
        gap = idle_cycles();
        note.typed = typed;
        note.want  = want;
        if (gap > 0)
        begin
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        typed_notes.push_back(note);
        item_bus.valid <= 1'b1;
        item_bus.data  <= w;
        @(posedge clk);
        while (!item_bus.ready) @(posedge clk);
    endtask

    task automatic drain();
        item_bus.valid <= 1'b0;
        @(posedge clk);
        while (status_expected.size() != 0) @(posedge clk);
    endtask

    task automatic set_limits(input logic [CNT_W-1:0] hi, input logic [CNT_W-1:0] lo,
                              input logic [CNT_W-1:0] rq, input logic [CNT_W-1:0] pl);
        cfg_we    <= 1'b1;
        cfg_index <= REG_SDA_HIGH_LIMIT;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_index <= REG_SDA_LOW_LIMIT;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= REG_REQUEST_LIMIT;
        cfg_data  <= rq;
        @(posedge clk);
        cfg_index <= REG_PULSE_LENGTH;
        cfg_data  <= pl;
        @(posedge clk);
        cfg_we <= 1'b0;
        lim_high    = hi;
        lim_low     = lo;
        lim_request = rq;
        lim_pulse   = pl;
    endtask

    task automatic report_mismatch(input string what, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t %s: expected relay/report_n/blocked/cause %b/%b/%b/%0d, got %b/%b/%b/%0d",
                     $realtime, what, want.relay_on, want.report_n, want.blocked, want.cause,
                     got.relay_on, got.report_n, got.blocked, got.cause);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        result_t       predicted;
        result_t       want;
        result_t       got;
        typed_status_t note;
        bit            busy;
        busy = 1'b0;
        if (rst_n)
        begin
            if (item_bus.valid && item_bus.ready)
            begin
                busy = 1'b1;
                predicted = next_status(item_bus.data);
                note = typed_notes.pop_front();
                status_expected.push_back(note.typed ? note.want : predicted);
                words_in++;
            end
            if (status_bus.valid && status_bus.ready)
            begin
                busy = 1'b1;
                got = status_bus.data;
                if (status_expected.size() == 0)
                    report_mismatch("status word with nothing expected", STATUS_IDLE, got);
                else
                begin
                    want = status_expected.pop_front();
                    if (got.relay_on !== want.relay_on || got.report_n !== want.report_n ||
                        got.blocked !== want.blocked || got.cause !== want.cause)
                        report_mismatch("status word mismatch", want, got);
                end
            end
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        int hold;
        bit long_hold_done;
        hold = 0;
        long_hold_done = 1'b0;
        status_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && words_in >= LONG_HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                hold = LONG_HOLD;
            end
            else if (hold == 0)
                hold = idle_cycles();
            if (hold > 0)
            begin
                status_bus.ready <= 1'b0;
                hold--;
            end
            else
                status_bus.ready <= 1'b1;
        end
    end

    initial
    begin
        item_t            w;
        int               p;
        int               left;
        int               run;
        int               run_max;
        int               edge_odds;
        logic             level;
        logic             asking;
        logic [CNT_W-1:0] hi;
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] rq;
        logic [CNT_W-1:0] pl;

        lim_high     = SDA_HIGH_LIMIT_RST;
        lim_low      = SDA_LOW_LIMIT_RST;
        lim_request  = REQUEST_LIMIT_RST;
        lim_pulse    = PULSE_LENGTH_RST;
        wd_high      = '0;
        wd_low       = '0;
        wd_request   = '0;
        wd_pulse     = '0;
        wd_blocked   = 1'b0;
        wd_cause     = CAUSE_NONE;
        wd_relay     = 1'b0;
        wd_report_n  = 1'b1;
        mismatches   = 0;
        words_in     = 0;
        quiet_cycles = 0;
        steady       = 1'b0;

        rst_n          <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_index      <= REG_SDA_HIGH_LIMIT;
        cfg_data       <= '0;
        item_bus.valid <= 1'b0;
        item_bus.data  <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < PROBE_ROWS; i++)
        begin
            if (i == PROBE_DEFAULT_ROWS)
            begin
                drain();
                set_limits(16'd2, 16'd0, 16'd1, 16'd1);
            end
            send_word(probe_rows[i].word, probe_rows[i].typed, probe_rows[i].want);
        end

        for (p = 0; p < PHASES; p++)
        begin
            drain();
            run_max   = 30;
            edge_odds = 12;
            case (p)
                0:
                begin
                    hi = SDA_HIGH_LIMIT_RST;
                    lo = SDA_LOW_LIMIT_RST;
                    rq = REQUEST_LIMIT_RST;
                    pl = PULSE_LENGTH_RST;
                    run_max   = 160;
                    edge_odds = 300;
                end
                1:
                begin
                    hi = '0;
                    lo = '0;
                    rq = '0;
                    pl = '0;
                end
                2:
                begin
                    hi = '1;
                    lo = '1;
                    rq = '1;
                    pl = '1;
                end
                4:
                begin
                    hi = CNT_W'($urandom_range(0, 12));
                    lo = CNT_W'($urandom_range(0, 12));
                    rq = CNT_W'($urandom_range(0, 12));
                    pl = '1;
                end
                7:
                begin
                    hi = CNT_W'($urandom_range(0, 40));
                    lo = CNT_W'($urandom_range(0, 40));
                    rq = CNT_W'($urandom_range(0, 40));
                    pl = CNT_W'($urandom_range(0, 30));
                end
                default:
                begin
                    hi = CNT_W'($urandom_range(0, 12));
                    lo = CNT_W'($urandom_range(0, 12));
                    rq = CNT_W'($urandom_range(0, 12));
                    pl = CNT_W'($urandom_range(0, 6));
                end
            endcase
            set_limits(hi, lo, rq, pl);
            steady = (p == 6);
            left = PHASE_WORDS;
            while (left > 0)
            begin
                run    = $urandom_range(1, run_max);
                level  = 1'($urandom_range(0, 1));
                asking = ($urandom_range(0, 3) == 0) ? 1'b0 : 1'b1;
                for (int k = 0; k < run && left > 0; k++)
                begin
                    w.operation     = ($urandom_range(0, edge_odds) == 0) ? OP_EDGE : OP_TICK;
                    w.sda_level     = level;
                    w.request_level = asking;
                    if (w.operation == OP_EDGE || $urandom_range(0, 15) == 0)
                    begin
                        w.sda_level     = 1'($urandom_range(0, 1));
                        w.request_level = 1'($urandom_range(0, 1));
                    end
                    send_word(w, 1'b0, STATUS_IDLE);
                    left--;
                end
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && status_expected.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ bus_stall_reset_watchdog.f @@
rtl/bsrw_pkg.sv
rtl/bsrw_if.sv
rtl/bsrw_cfg.sv
rtl/bsrw_core.sv
rtl/bus_stall_reset_watchdog.sv
rtl/bsrw_checker.sv
sim/bus_stall_reset_watchdog_tb.sv
